### sv/gate_pulse_width_detector_defines.svh
// Assertion macros for the gate pulse width detector.
`ifndef GATE_PULSE_WIDTH_DETECTOR_DEFINES_SVH
`define GATE_PULSE_WIDTH_DETECTOR_DEFINES_SVH

`ifndef SYNTH
`define GPW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpw assertion failed");
`define GPW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpw assertion failed");
`else
`define GPW_ASSERT_NOW(label, ante, cons)
`define GPW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/gpw_pkg.sv
// Shared types and constants for the gate pulse width detector.
package gpw_pkg;

  localparam int FIELD_W = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_LEVEL_INV  = 2'd0;
  localparam reg_idx_t REG_LOW_LIMIT  = 2'd1;
  localparam reg_idx_t REG_HIGH_LIMIT = 2'd2;
  localparam reg_idx_t REG_DB_LENGTH  = 2'd3;

  localparam logic [7:0]         DB_LENGTH_RESET  = 8'd3;
  localparam logic [FIELD_W-1:0] HIGH_LIMIT_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic valid;
    logic level;
  } stage_ctl_t;

endpackage

### sv/gpw_cfg.sv
// APB register file: level inversion, width limits and debounce length.
module gpw_cfg #(
  parameter int COUNT_BITS    = 32,
  parameter int DEBOUNCE_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpw_pkg::ADDR_W-1:0]   paddr,
  input  logic [gpw_pkg::DATA_W-1:0]   pwdata,
  output logic [gpw_pkg::DATA_W-1:0]   prdata,
  output logic                         level_inv,
  output logic [COUNT_BITS-1:0]        low_limit,
  output logic [COUNT_BITS-1:0]        high_limit,
  output logic [DEBOUNCE_BITS-1:0]     db_length
);

  gpw_pkg::reg_idx_t idx;
  logic              wr;

  assign idx = paddr[3:2];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_inv  <= 1'b0;
      low_limit  <= '0;
      high_limit <= COUNT_BITS'(gpw_pkg::HIGH_LIMIT_RESET);
      db_length  <= DEBOUNCE_BITS'(gpw_pkg::DB_LENGTH_RESET);
    end else if (wr) begin
      case (idx)
        gpw_pkg::REG_LEVEL_INV:  level_inv  <= pwdata[0];
        gpw_pkg::REG_LOW_LIMIT:  low_limit  <= COUNT_BITS'(pwdata);
        gpw_pkg::REG_HIGH_LIMIT: high_limit <= COUNT_BITS'(pwdata);
        gpw_pkg::REG_DB_LENGTH:  db_length  <= DEBOUNCE_BITS'(pwdata[7:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gpw_pkg::REG_LEVEL_INV:  prdata = gpw_pkg::DATA_W'(level_inv);
      gpw_pkg::REG_LOW_LIMIT:  prdata = gpw_pkg::DATA_W'(low_limit);
      gpw_pkg::REG_HIGH_LIMIT: prdata = gpw_pkg::DATA_W'(high_limit);
      gpw_pkg::REG_DB_LENGTH:  prdata = gpw_pkg::DATA_W'(db_length);
      default:                 prdata = '0;
    endcase
  end

endmodule

### sv/gpw_front.sv
// Input register stage: samples the gate level (after inversion) and count.
module gpw_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic                        raw_level,
  input  logic [gpw_pkg::FIELD_W-1:0] position_count,
  input  logic                        level_inv,
  output gpw_pkg::stage_ctl_t         s1_ctl,
  output logic [COUNT_BITS-1:0]       s1_count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else if (adv) begin
      s1_ctl.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_ctl.level <= raw_level ^ level_inv;
      s1_count     <= COUNT_BITS'(position_count);
    end
  end

endmodule

### sv/gpw_core.sv
// Debounce, start tracking, width qualification and result register.
module gpw_core #(
  parameter int COUNT_BITS    = 32,
  parameter int DEBOUNCE_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  gpw_pkg::stage_ctl_t      s1_ctl,
  input  logic [COUNT_BITS-1:0]    s1_count,
  input  logic [COUNT_BITS-1:0]    low_limit,
  input  logic [COUNT_BITS-1:0]    high_limit,
  input  logic [DEBOUNCE_BITS-1:0] db_length,
  output logic                     res_valid,
  output logic [COUNT_BITS-1:0]    res_start,
  output logic [COUNT_BITS-1:0]    res_end,
  output logic [COUNT_BITS-1:0]    res_mid,
  output logic [COUNT_BITS-1:0]    res_width
);

  localparam logic [DEBOUNCE_BITS-1:0] DB_RESET =
    DEBOUNCE_BITS'(gpw_pkg::DB_LENGTH_RESET);

  logic                     acc_level;
  logic [DEBOUNCE_BITS-1:0] db_left;
  logic [COUNT_BITS-1:0]    start_mark;

  logic                     acc_level_next;
  logic [DEBOUNCE_BITS-1:0] db_left_next;
  logic [COUNT_BITS-1:0]    start_mark_next;
  logic [DEBOUNCE_BITS-1:0] db_dec;
  logic [COUNT_BITS-1:0]    width;
  logic                     edge_seen;
  logic                     hit;

  assign db_dec = db_left - DEBOUNCE_BITS'(1);
  assign width  = s1_count - start_mark;

  always_comb begin
    acc_level_next  = acc_level;
    db_left_next    = db_left;
    start_mark_next = start_mark;
    edge_seen       = 1'b0;
    hit             = 1'b0;
    if (s1_ctl.level == acc_level) begin
      db_left_next = db_length;
      if (!s1_ctl.level) begin
        start_mark_next = s1_count;
      end
    end else if (db_dec == '0) begin
      edge_seen    = 1'b1;
      db_left_next = db_length;
    end else begin
      db_left_next = db_dec;
    end
    if (edge_seen) begin
      acc_level_next = s1_ctl.level;
      if (!s1_ctl.level) begin
        start_mark_next = s1_count;
        hit = (start_mark != '1) && (s1_count != '1) &&
              (width > low_limit) && (width < high_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_level  <= 1'b0;
      db_left    <= DB_RESET;
      start_mark <= '1;
      res_valid  <= 1'b0;
    end else if (adv) begin
      res_valid <= s1_ctl.valid && hit;
      if (s1_ctl.valid) begin
        acc_level  <= acc_level_next;
        db_left    <= db_left_next;
        start_mark <= start_mark_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_ctl.valid && hit) begin
      res_start <= start_mark;
      res_end   <= s1_count;
      res_mid   <= start_mark + (width >> 1);
      res_width <= width;
    end
  end

endmodule

### sv/gate_pulse_width_detector.sv
// Top level of the gate pulse width detector.
// Takes one gate sample word per clock while in_stall is low, each with its
// encoder count, and emits a word for each accepted high-to-low edge whose
// pulse width lies strictly between low_limit and high_limit. Words pass an
// input register and then a result register before a result word is offered,
// and the block takes one sample per cycle while not stalled. The result
// register holds while out_stall is high; in_stall is high exactly while a
// result waits there, and no sample is taken in those cycles. A level change
// counts only after debounce_length consecutive differing samples (a length
// of zero means 2^DEBOUNCE_BITS samples).
`include "gate_pulse_width_detector_defines.svh"

module gate_pulse_width_detector #(
  parameter int COUNT_BITS    = 32,
  parameter int DEBOUNCE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpw_pkg::ADDR_W-1:0]  paddr,
  input  logic [gpw_pkg::DATA_W-1:0]  pwdata,
  output logic [gpw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        raw_level,
  input  logic [gpw_pkg::FIELD_W-1:0] position_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gpw_pkg::FIELD_W-1:0] start_count,
  output logic [gpw_pkg::FIELD_W-1:0] end_count,
  output logic [gpw_pkg::FIELD_W-1:0] middle_count,
  output logic [gpw_pkg::FIELD_W-1:0] pulse_width
);

  logic                     level_inv;
  logic [COUNT_BITS-1:0]    low_limit;
  logic [COUNT_BITS-1:0]    high_limit;
  logic [DEBOUNCE_BITS-1:0] db_length;
  logic                     adv;
  gpw_pkg::stage_ctl_t      s1_ctl;
  logic [COUNT_BITS-1:0]    s1_count;
  logic [COUNT_BITS-1:0]    res_start;
  logic [COUNT_BITS-1:0]    res_end;
  logic [COUNT_BITS-1:0]    res_mid;
  logic [COUNT_BITS-1:0]    res_width;

  assign pready   = 1'b1;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  gpw_cfg #(
    .COUNT_BITS   (COUNT_BITS),
    .DEBOUNCE_BITS(DEBOUNCE_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .level_inv (level_inv),
    .low_limit (low_limit),
    .high_limit(high_limit),
    .db_length (db_length)
  );

  gpw_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (in_valid),
    .raw_level     (raw_level),
    .position_count(position_count),
    .level_inv     (level_inv),
    .s1_ctl        (s1_ctl),
    .s1_count      (s1_count)
  );

  gpw_core #(
    .COUNT_BITS   (COUNT_BITS),
    .DEBOUNCE_BITS(DEBOUNCE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_ctl    (s1_ctl),
    .s1_count  (s1_count),
    .low_limit (low_limit),
    .high_limit(high_limit),
    .db_length (db_length),
    .res_valid (out_valid),
    .res_start (res_start),
    .res_end   (res_end),
    .res_mid   (res_mid),
    .res_width (res_width)
  );

  assign start_count  = gpw_pkg::FIELD_W'(res_start);
  assign end_count    = gpw_pkg::FIELD_W'(res_end);
  assign middle_count = gpw_pkg::FIELD_W'(res_mid);
  assign pulse_width  = gpw_pkg::FIELD_W'(res_width);

  `GPW_ASSERT_NEXT(a_no_word_no_result, !s1_ctl.valid && adv, !out_valid)
  `GPW_ASSERT_NOW(a_width_matches, out_valid, res_width == res_end - res_start)
  `GPW_ASSERT_NOW(a_mid_matches, out_valid, res_mid == res_start + (res_width >> 1))

endmodule

### tb/testbench.sv
// Self-checking testbench for the gate pulse width detector.
module testbench;

  typedef struct packed {
    logic [gpw_pkg::FIELD_W-1:0] start_c;
    logic [gpw_pkg::FIELD_W-1:0] end_c;
    logic [gpw_pkg::FIELD_W-1:0] mid_c;
    logic [gpw_pkg::FIELD_W-1:0] width;
  } pulse_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_EVENT} row_kind_t;

  typedef struct packed {
    logic                        raw;
    logic [gpw_pkg::FIELD_W-1:0] cnt;
    row_kind_t                   kind;
    pulse_t                      ev;
  } row_t;

  localparam int NUM_ROWS   = 29;
  localparam int NUM_PHASES = 6;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [gpw_pkg::ADDR_W-1:0]  paddr = '0;
  logic [gpw_pkg::DATA_W-1:0]  pwdata = '0;
  logic [gpw_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        raw_level = 1'b0;
  logic [gpw_pkg::FIELD_W-1:0] position_count = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [gpw_pkg::FIELD_W-1:0] start_count;
  logic [gpw_pkg::FIELD_W-1:0] end_count;
  logic [gpw_pkg::FIELD_W-1:0] middle_count;
  logic [gpw_pkg::FIELD_W-1:0] pulse_width;

  gate_pulse_width_detector u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .raw_level(raw_level), .position_count(position_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .start_count(start_count), .end_count(end_count),
    .middle_count(middle_count), .pulse_width(pulse_width)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow registers and detector state
  logic                        sh_level_inv;
  logic [gpw_pkg::FIELD_W-1:0] sh_low_limit;
  logic [gpw_pkg::FIELD_W-1:0] sh_high_limit;
  logic [7:0]                  sh_db_length;
  logic                        acc_level;
  logic [7:0]                  db_left;
  logic [gpw_pkg::FIELD_W-1:0] start_mark;

  pulse_t      pulse_q[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned stall_tick = 0;

  logic [0:0]                  ph_inv   [NUM_PHASES] =
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [gpw_pkg::FIELD_W-1:0] ph_min   [NUM_PHASES] =
    '{32'd0, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd50, 32'd30};
  logic [gpw_pkg::FIELD_W-1:0] ph_max   [NUM_PHASES] =
    '{32'hFFFF_FFFF, 32'd250, 32'd0, 32'hFFFF_FFFF, 32'd2000000, 32'd400};
  logic [7:0]                  ph_db    [NUM_PHASES] =
    '{8'd3, 8'd1, 8'd2, 8'd255, 8'd0, 8'd4};
  int                          ph_items [NUM_PHASES] = '{300, 280, 100, 350, 450, 200};

  task automatic report_mismatch(input string what,
                                 input logic [gpw_pkg::FIELD_W-1:0] got,
                                 input logic [gpw_pkg::FIELD_W-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic qualify_sample(input logic raw, input logic [gpw_pkg::FIELD_W-1:0] cnt,
                                output logic hit, output pulse_t ev);
    logic                        lvl;
    logic                        took;
    logic [gpw_pkg::FIELD_W-1:0] w;
    lvl  = raw ^ sh_level_inv;
    hit  = 1'b0;
    ev   = '0;
    took = 1'b0;
    if (lvl == acc_level) begin
      db_left = sh_db_length;
      if (!lvl) start_mark = cnt;
    end else begin
      db_left = db_left - 8'd1;
      if (db_left == 8'd0) begin
        took    = 1'b1;
        db_left = sh_db_length;
      end
    end
    if (took) begin
      acc_level = lvl;
      if (!lvl) begin
        w = cnt - start_mark;
        if (start_mark != '1 && cnt != '1 && w > sh_low_limit && w < sh_high_limit) begin
          hit = 1'b1;
          ev  = '{start_mark, cnt, start_mark + (w >> 1), w};
        end
        start_mark = cnt;
      end
    end
  endtask

  task automatic send_sample(input row_t r);
    logic   hit;
    pulse_t ev;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    burst_left--;
    in_valid       <= 1'b1;
    raw_level      <= r.raw;
    position_count <= r.cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    qualify_sample(r.raw, r.cnt, hit, ev);
    case (r.kind)
      ROW_PREDICT: if (hit) pulse_q.push_back(ev);
      ROW_EVENT:   pulse_q.push_back(r.ev);
      default:     ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input gpw_pkg::reg_idx_t idx,
                           input logic [gpw_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      gpw_pkg::REG_LEVEL_INV:  sh_level_inv  = val[0];
      gpw_pkg::REG_LOW_LIMIT:  sh_low_limit  = val;
      gpw_pkg::REG_HIGH_LIMIT: sh_high_limit = val;
      gpw_pkg::REG_DB_LENGTH:  sh_db_length  = val[7:0];
      default:                 ;
    endcase
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= (stall_tick[2:0] < 3);
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  always @(posedge clk) begin
    pulse_t want;
    if (out_valid && !out_stall) begin
      if (pulse_q.size() == 0) begin
        report_mismatch("unexpected word", start_count, '0);
      end else begin
        want = pulse_q.pop_front();
        if (start_count !== want.start_c)
          report_mismatch("start_count", start_count, want.start_c);
        if (end_count !== want.end_c)
          report_mismatch("end_count", end_count, want.end_c);
        if (middle_count !== want.mid_c)
          report_mismatch("middle_count", middle_count, want.mid_c);
        if (pulse_width !== want.width)
          report_mismatch("pulse_width", pulse_width, want.width);
      end
    end
  end

  initial begin
    row_t                        dir_rows [NUM_ROWS];
    row_t                        item;
    logic [gpw_pkg::FIELD_W-1:0] cnt;
    logic                        lvl;
    logic                        cur;
    logic                        noisy;
    int                          eff;
    int                          len;
    int                          sent;
    int                          pick;

    sh_level_inv  = 1'b0;
    sh_low_limit  = '0;
    sh_high_limit = gpw_pkg::HIGH_LIMIT_RESET;
    sh_db_length  = gpw_pkg::DB_LENGTH_RESET;
    acc_level     = 1'b0;
    db_left       = gpw_pkg::DB_LENGTH_RESET;
    start_mark    = '1;

    dir_rows = '{
      '{1'b0, 32'd100,        ROW_NONE,    '0},
      '{1'b1, 32'd105,        ROW_PREDICT, '0},
      '{1'b1, 32'd106,        ROW_PREDICT, '0},
      '{1'b1, 32'd107,        ROW_PREDICT, '0},
      '{1'b0, 32'd120,        ROW_PREDICT, '0},
      '{1'b1, 32'd121,        ROW_PREDICT, '0},
      '{1'b0, 32'd130,        ROW_PREDICT, '0},
      '{1'b0, 32'd131,        ROW_PREDICT, '0},
      '{1'b0, 32'd140,        ROW_EVENT,   '{32'd100, 32'd140, 32'd120, 32'd40}},
      '{1'b0, 32'hFFFF_FFF0,  ROW_PREDICT, '0},
      '{1'b1, 32'hFFFF_FFF4,  ROW_PREDICT, '0},
      '{1'b1, 32'hFFFF_FFF8,  ROW_PREDICT, '0},
      '{1'b1, 32'hFFFF_FFFC,  ROW_PREDICT, '0},
      '{1'b0, 32'h0000_0008,  ROW_PREDICT, '0},
      '{1'b0, 32'h0000_000C,  ROW_PREDICT, '0},
      '{1'b0, 32'h0000_0012,  ROW_EVENT,
        '{32'hFFFF_FFF0, 32'h0000_0012, 32'h0000_0001, 32'h0000_0022}},
      '{1'b0, 32'hFFFF_FFFF,  ROW_PREDICT, '0},
      '{1'b1, 32'h20,         ROW_PREDICT, '0},
      '{1'b1, 32'h21,         ROW_PREDICT, '0},
      '{1'b1, 32'h22,         ROW_PREDICT, '0},
      '{1'b0, 32'h30,         ROW_PREDICT, '0},
      '{1'b0, 32'h31,         ROW_PREDICT, '0},
      '{1'b0, 32'h32,         ROW_NONE,    '0},
      '{1'b1, 32'h40,         ROW_PREDICT, '0},
      '{1'b1, 32'h41,         ROW_PREDICT, '0},
      '{1'b1, 32'h42,         ROW_PREDICT, '0},
      '{1'b0, 32'h50,         ROW_PREDICT, '0},
      '{1'b0, 32'h51,         ROW_PREDICT, '0},
      '{1'b0, 32'hFFFF_FFFF,  ROW_NONE,    '0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) send_sample(dir_rows[i]);

    cnt = 32'h0000_1000;
    cur = 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        reg_write(gpw_pkg::REG_LEVEL_INV, {31'd0, ph_inv[p]});
        reg_write(gpw_pkg::REG_LOW_LIMIT, ph_min[p]);
        reg_write(gpw_pkg::REG_HIGH_LIMIT, ph_max[p]);
        reg_write(gpw_pkg::REG_DB_LENGTH, {24'd0, ph_db[p]});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
      end
      // zero length wraps to a full 2^8 sample debounce
      eff  = (ph_db[p] == 8'd0) ? 256 : int'(ph_db[p]);
      sent = 0;
      while (sent < ph_items[p]) begin
        pick  = $urandom_range(0, 9);
        noisy = 1'b0;
        lvl   = ~cur;
        if (pick < 7 || eff < 2) begin
          len = eff + $urandom_range(0, eff / 4 + 3);
          cur = lvl;
        end else if (pick < 9) begin
          len = $urandom_range(1, eff - 1);
        end else begin
          len   = $urandom_range(1, 4);
          noisy = 1'b1;
        end
        for (int t = 0; t < len; t++) begin
          pick = $urandom_range(0, 99);
          if (pick == 0) cnt = '1;
          else if (pick < 3) cnt = $urandom;
          else cnt = cnt + $urandom_range(0, 40);
          item.raw  = (noisy ? 1'($urandom_range(0, 1)) : lvl) ^ sh_level_inv;
          item.cnt  = cnt;
          item.kind = ROW_PREDICT;
          item.ev   = '0;
          send_sample(item);
          sent++;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
